// File: sv/tahc_pkg.sv
`default_nettype none
package tahc_pkg;

  localparam int VALUE_WIDTH     = 40;
  localparam int TIME_WIDTH      = 48;
  localparam int MS_WIDTH        = 32;
  localparam int PCT_WIDTH       = 14;
  localparam int RATE_WIDTH      = 40;
  localparam int THRESH_WIDTH    = 40;
  localparam int CFG_DATA_WIDTH  = 40;
  localparam int CFG_INDEX_WIDTH = 3;
  localparam int METRIC_WIDTH    = 3;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_PENDING   = 2'd1,
    PH_TRIGGERED = 2'd2,
    PH_COOLDOWN  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_NONE      = 2'd0,
    EV_TRIGGERED = 2'd1,
    EV_CLEARED   = 2'd2,
    EV_ACKED     = 2'd3
  } event_t;

  localparam logic OP_EVAL = 1'b0;
  localparam logic OP_ACK  = 1'b1;

  localparam logic [METRIC_WIDTH-1:0] MS_CPU        = 3'd0;
  localparam logic [METRIC_WIDTH-1:0] MS_MEMORY     = 3'd1;
  localparam logic [METRIC_WIDTH-1:0] MS_DISK_READ  = 3'd2;
  localparam logic [METRIC_WIDTH-1:0] MS_DISK_WRITE = 3'd3;
  localparam logic [METRIC_WIDTH-1:0] MS_NET_RECV   = 3'd4;
  localparam logic [METRIC_WIDTH-1:0] MS_NET_SENT   = 3'd5;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_RULE_ENABLE   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_METRIC_SELECT = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COMPARE_BELOW = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_THRESHOLD     = 3'd3;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_HOLD_MS       = 3'd4;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_COOLDOWN_MS   = 3'd5;

  typedef struct packed {
    logic                      rule_enable;
    logic [METRIC_WIDTH-1:0]   metric_select;
    logic                      compare_below;
    logic [THRESH_WIDTH-1:0]   threshold;
    logic [MS_WIDTH-1:0]       hold_ms;
    logic [MS_WIDTH-1:0]       cooldown_ms;
  } cfg_t;

  typedef struct packed {
    logic                    opcode;
    logic [TIME_WIDTH-1:0]   timestamp_ms;
    logic [PCT_WIDTH-1:0]    cpu_hundredths;
    logic [PCT_WIDTH-1:0]    memory_hundredths;
    logic [RATE_WIDTH-1:0]   disk_read_rate;
    logic [RATE_WIDTH-1:0]   disk_write_rate;
    logic [RATE_WIDTH-1:0]   net_recv_rate;
    logic [RATE_WIDTH-1:0]   net_sent_rate;
  } item_t;

  typedef struct packed {
    phase_t                  alarm_state;
    event_t                  event_kind;
    logic [TIME_WIDTH-1:0]   event_time;
    logic [VALUE_WIDTH-1:0]  event_value;
    logic [VALUE_WIDTH-1:0]  latest_value;
    logic [VALUE_WIDTH-1:0]  peak_seen;
    logic [TIME_WIDTH-1:0]   trigger_time;
    logic                    acked;
    logic [TIME_WIDTH-1:0]   active_duration;
    logic                    ack_rejected;
  } result_t;

  // backward time counts as zero elapsed
  function automatic logic [TIME_WIDTH-1:0] elapsed_since(
    input logic [TIME_WIDTH-1:0] now,
    input logic [TIME_WIDTH-1:0] start
  );
    return (now >= start) ? (now - start) : '0;
  endfunction

endpackage
`default_nettype wire

// File: sv/tahc_in_reg.sv
`default_nettype none
module tahc_in_reg (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_opcode,
  input  logic [tahc_pkg::TIME_WIDTH-1:0]      in_timestamp_ms,
  input  logic [tahc_pkg::PCT_WIDTH-1:0]       in_cpu_hundredths,
  input  logic [tahc_pkg::PCT_WIDTH-1:0]       in_memory_hundredths,
  input  logic [tahc_pkg::RATE_WIDTH-1:0]      in_disk_read_rate,
  input  logic [tahc_pkg::RATE_WIDTH-1:0]      in_disk_write_rate,
  input  logic [tahc_pkg::RATE_WIDTH-1:0]      in_net_recv_rate,
  input  logic [tahc_pkg::RATE_WIDTH-1:0]      in_net_sent_rate,
  input  logic                                 advance,
  output logic                                 item_valid,
  output tahc_pkg::item_t                      item
);
  import tahc_pkg::*;

  logic  valid_r;
  item_t item_r;
  logic  load;

  assign in_ready   = !valid_r || advance;
  assign load       = in_valid && in_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.opcode            <= in_opcode;
      item_r.timestamp_ms      <= in_timestamp_ms;
      item_r.cpu_hundredths    <= in_cpu_hundredths;
      item_r.memory_hundredths <= in_memory_hundredths;
      item_r.disk_read_rate    <= in_disk_read_rate;
      item_r.disk_write_rate   <= in_disk_write_rate;
      item_r.net_recv_rate     <= in_net_recv_rate;
      item_r.net_sent_rate     <= in_net_sent_rate;
    end
  end

endmodule
`default_nettype wire

// File: sv/tahc_alarm_fsm.sv
`default_nettype none
module tahc_alarm_fsm (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  tahc_pkg::cfg_t    cfg,
  input  tahc_pkg::item_t   item,
  output tahc_pkg::result_t result
);
  import tahc_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [TIME_WIDTH-1:0]  pending_start_r, pending_start_nxt;
  logic [TIME_WIDTH-1:0]  cooldown_start_r, cooldown_start_nxt;
  logic [TIME_WIDTH-1:0]  trig_stamp_r, trig_stamp_nxt;
  logic [VALUE_WIDTH-1:0] peak_r, peak_nxt;
  logic [VALUE_WIDTH-1:0] last_value_r, last_value_nxt;
  logic [TIME_WIDTH-1:0]  last_eval_r, last_eval_nxt;
  logic                   ack_r, ack_nxt;

  logic [VALUE_WIDTH-1:0] value;
  logic [TIME_WIDTH-1:0]  now;
  logic                   cond;
  logic                   is_eval;
  logic                   is_ack;
  logic                   hold_met;
  logic                   cool_met;
  logic                   hold_zero;
  logic                   cool_zero;
  logic                   peak_better;

  event_t                 ev_kind;
  logic [TIME_WIDTH-1:0]  ev_time;
  logic [VALUE_WIDTH-1:0] ev_value;
  logic                   rejected;

  assign now = item.timestamp_ms;

  always_comb begin
    unique case (cfg.metric_select)
      MS_CPU:        value = VALUE_WIDTH'(item.cpu_hundredths);
      MS_MEMORY:     value = VALUE_WIDTH'(item.memory_hundredths);
      MS_DISK_READ:  value = VALUE_WIDTH'(item.disk_read_rate);
      MS_DISK_WRITE: value = VALUE_WIDTH'(item.disk_write_rate);
      MS_NET_RECV:   value = VALUE_WIDTH'(item.net_recv_rate);
      MS_NET_SENT:   value = VALUE_WIDTH'(item.net_sent_rate);
      default:       value = '0;
    endcase
  end

  assign cond = cfg.compare_below ? (value < VALUE_WIDTH'(cfg.threshold))
                                  : (value > VALUE_WIDTH'(cfg.threshold));
  assign is_eval   = step && (item.opcode == OP_EVAL) && cfg.rule_enable;
  assign is_ack    = step && (item.opcode == OP_ACK);
  assign hold_zero = (cfg.hold_ms == '0);
  assign cool_zero = (cfg.cooldown_ms == '0);
  assign hold_met  = elapsed_since(now, pending_start_r) >= TIME_WIDTH'(cfg.hold_ms);
  assign cool_met  = elapsed_since(now, cooldown_start_r) >= TIME_WIDTH'(cfg.cooldown_ms);
  assign peak_better = cfg.compare_below ? (value < peak_r) : (value > peak_r);

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (is_eval) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (cond) phase_nxt = hold_zero ? PH_TRIGGERED : PH_PENDING;
        end
        PH_PENDING: begin
          if (!cond)         phase_nxt = PH_IDLE;
          else if (hold_met) phase_nxt = PH_TRIGGERED;
        end
        PH_TRIGGERED: begin
          if (!cond) phase_nxt = cool_zero ? PH_IDLE : PH_COOLDOWN;
        end
        PH_COOLDOWN: begin
          if (cool_met) phase_nxt = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  // alarm data and event report
  always_comb begin
    pending_start_nxt  = pending_start_r;
    cooldown_start_nxt = cooldown_start_r;
    trig_stamp_nxt     = trig_stamp_r;
    peak_nxt           = peak_r;
    last_value_nxt     = last_value_r;
    last_eval_nxt      = last_eval_r;
    ack_nxt            = ack_r;
    ev_kind            = EV_NONE;
    ev_time            = '0;
    ev_value           = '0;
    rejected           = 1'b0;
    if (is_ack) begin
      if (!cfg.rule_enable || phase_r != PH_TRIGGERED) begin
        rejected = 1'b1;
      end else begin
        ack_nxt  = 1'b1;
        ev_kind  = EV_ACKED;
        ev_time  = last_eval_r;
        ev_value = last_value_r;
      end
    end else if (is_eval) begin
      last_value_nxt = value;
      last_eval_nxt  = now;
      unique case (phase_r)
        PH_IDLE: begin
          if (cond) begin
            peak_nxt = value;
            if (hold_zero) begin
              trig_stamp_nxt = now;
              ack_nxt        = 1'b0;
              ev_kind        = EV_TRIGGERED;
              ev_time        = now;
              ev_value       = value;
            end else begin
              pending_start_nxt = now;
            end
          end
        end
        PH_PENDING: begin
          if (cond) begin
            if (peak_better) peak_nxt = value;
            if (hold_met) begin
              trig_stamp_nxt = now;
              ack_nxt        = 1'b0;
              ev_kind        = EV_TRIGGERED;
              ev_time        = now;
              ev_value       = value;
            end
          end else begin
            pending_start_nxt = '0;
            peak_nxt          = '0;
          end
        end
        PH_TRIGGERED: begin
          if (cond) begin
            if (peak_better) peak_nxt = value;
          end else begin
            ev_kind  = EV_CLEARED;
            ev_time  = now;
            ev_value = value;
            if (cool_zero) begin
              trig_stamp_nxt = '0;
              peak_nxt       = '0;
              ack_nxt        = 1'b0;
            end else begin
              cooldown_start_nxt = now;
            end
          end
        end
        PH_COOLDOWN: begin
          if (cool_met) begin
            trig_stamp_nxt = '0;
            peak_nxt       = '0;
            ack_nxt        = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    result.alarm_state     = phase_nxt;
    result.event_kind      = ev_kind;
    result.event_time      = ev_time;
    result.event_value     = ev_value;
    result.latest_value    = last_value_nxt;
    result.peak_seen       = peak_nxt;
    result.trigger_time    = trig_stamp_nxt;
    result.acked           = ack_nxt;
    result.active_duration = (phase_nxt == PH_TRIGGERED)
                             ? elapsed_since(last_eval_nxt, trig_stamp_nxt) : '0;
    result.ack_rejected    = rejected;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      pending_start_r  <= '0;
      cooldown_start_r <= '0;
      trig_stamp_r     <= '0;
      peak_r           <= '0;
      last_value_r     <= '0;
      last_eval_r      <= '0;
      ack_r            <= 1'b0;
    end else begin
      phase_r          <= phase_nxt;
      pending_start_r  <= pending_start_nxt;
      cooldown_start_r <= cooldown_start_nxt;
      trig_stamp_r     <= trig_stamp_nxt;
      peak_r           <= peak_nxt;
      last_value_r     <= last_value_nxt;
      last_eval_r      <= last_eval_nxt;
      ack_r            <= ack_nxt;
    end
  end

  a_ack_only_when_raised: assert property (@(posedge clk) disable iff (!rst_n)
    ack_r |-> (phase_r == PH_TRIGGERED || phase_r == PH_COOLDOWN))
    else $error("ack flag set outside triggered or cooldown");

  a_no_stamp_before_trigger: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE || phase_r == PH_PENDING) |-> (trig_stamp_r == '0))
    else $error("trigger stamp held while not raised");

  a_idle_no_peak: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (peak_r == '0))
    else $error("peak held while idle");

  a_trigger_event_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_kind == EV_TRIGGERED) |-> (phase_nxt == PH_TRIGGERED && step))
    else $error("trigger event without entering triggered phase");

  a_hold_without_item: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> ($stable(phase_r) && $stable(ack_r)))
    else $error("alarm state moved with no item");

endmodule
`default_nettype wire

// File: sv/threshold_alert_hold_cooldown_core.sv
`default_nettype none
// Single-rule threshold alarm with hold time and cooldown. Each item either
// evaluates a metrics snapshot against the configured rule or acknowledges a
// raised alarm, and returns exactly one status item. Throughput is one item
// per clock while the output is not stalled by out_ready; an item is accepted
// into the input register, and the alarm state machine updates its state as
// the result register loads once that register is free or draining. The state
// loop through the alarm state machine is what sets the one-item-per-clock
// figure. The configuration port is always ready; write it only while no item
// is in flight.
module threshold_alert_hold_cooldown_core (
  input  logic                                   clk,
  input  logic                                   rst_n,

  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [tahc_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
  input  logic [tahc_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,

  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   in_opcode,
  input  logic [tahc_pkg::TIME_WIDTH-1:0]        in_timestamp_ms,
  input  logic [tahc_pkg::PCT_WIDTH-1:0]         in_cpu_hundredths,
  input  logic [tahc_pkg::PCT_WIDTH-1:0]         in_memory_hundredths,
  input  logic [tahc_pkg::RATE_WIDTH-1:0]        in_disk_read_rate,
  input  logic [tahc_pkg::RATE_WIDTH-1:0]        in_disk_write_rate,
  input  logic [tahc_pkg::RATE_WIDTH-1:0]        in_net_recv_rate,
  input  logic [tahc_pkg::RATE_WIDTH-1:0]        in_net_sent_rate,

  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [1:0]                             out_alarm_state,
  output logic [1:0]                             out_event_kind,
  output logic [tahc_pkg::TIME_WIDTH-1:0]        out_event_time,
  output logic [tahc_pkg::VALUE_WIDTH-1:0]       out_event_value,
  output logic [tahc_pkg::VALUE_WIDTH-1:0]       out_latest_value,
  output logic [tahc_pkg::VALUE_WIDTH-1:0]       out_peak_seen,
  output logic [tahc_pkg::TIME_WIDTH-1:0]        out_trigger_time,
  output logic                                   out_acked,
  output logic [tahc_pkg::TIME_WIDTH-1:0]        out_active_duration,
  output logic                                   out_ack_rejected
);
  import tahc_pkg::*;

  cfg_t    cfg_r;
  item_t   item;
  logic    item_valid;
  logic    step;
  result_t result;
  result_t result_r;
  logic    out_valid_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RULE_ENABLE:   cfg_r.rule_enable   <= cfg_data[0];
        REG_METRIC_SELECT: cfg_r.metric_select <= cfg_data[METRIC_WIDTH-1:0];
        REG_COMPARE_BELOW: cfg_r.compare_below <= cfg_data[0];
        REG_THRESHOLD:     cfg_r.threshold     <= cfg_data[THRESH_WIDTH-1:0];
        REG_HOLD_MS:       cfg_r.hold_ms       <= cfg_data[MS_WIDTH-1:0];
        REG_COOLDOWN_MS:   cfg_r.cooldown_ms   <= cfg_data[MS_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // advance an item whenever the result register is free or draining
  assign step = item_valid && (!out_valid_r || out_ready);

  tahc_in_reg u_in_reg (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_opcode            (in_opcode),
    .in_timestamp_ms      (in_timestamp_ms),
    .in_cpu_hundredths    (in_cpu_hundredths),
    .in_memory_hundredths (in_memory_hundredths),
    .in_disk_read_rate    (in_disk_read_rate),
    .in_disk_write_rate   (in_disk_write_rate),
    .in_net_recv_rate     (in_net_recv_rate),
    .in_net_sent_rate     (in_net_sent_rate),
    .advance              (step),
    .item_valid           (item_valid),
    .item                 (item)
  );

  tahc_alarm_fsm u_alarm_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .cfg    (cfg_r),
    .item   (item),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_r <= result;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_alarm_state     = result_r.alarm_state;
  assign out_event_kind      = result_r.event_kind;
  assign out_event_time      = result_r.event_time;
  assign out_event_value     = result_r.event_value;
  assign out_latest_value    = result_r.latest_value;
  assign out_peak_seen       = result_r.peak_seen;
  assign out_trigger_time    = result_r.trigger_time;
  assign out_acked           = result_r.acked;
  assign out_active_duration = result_r.active_duration;
  assign out_ack_rejected    = result_r.ack_rejected;

endmodule
`default_nettype wire
